[hw/rtl/pppt_pkg.sv]
package pppt_pkg;

	localparam int PAD_W = 3;
	localparam int SAMPLE_W = 10;
	localparam int THR_W = 10;
	localparam int MS_W = 8;
	localparam int NOTE_W = 7;
	localparam int VEL_W = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;
	localparam int NUM_THR_REGS = 6;

	localparam int NUM_PADS_DEF = 6;
	localparam int SAMPLE_MAX_DEF = 1023;

	localparam logic [CFG_IDX_W-1:0] REG_PEAK_WINDOW = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET_WINDOW = 3'd7;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic EV_NOTE_ON = 1'b0;
	localparam logic EV_NOTE_OFF = 1'b1;

	localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;
	localparam logic [VEL_W-1:0] VEL_MIN = 7'd1;
	localparam logic [VEL_W-1:0] VEL_OFF = 7'd0;
	localparam logic [MS_W-1:0] TIMER_MAX = 8'hFF;

	localparam logic [MS_W-1:0] PEAK_WINDOW_RST = 8'd12;
	localparam logic [MS_W-1:0] QUIET_WINDOW_RST = 8'd25;

	// Pads beyond the sixth share the threshold and note of pad (index mod 6).
	function automatic logic [PAD_W-1:0] thr_slot(input logic [PAD_W-1:0] p);
		thr_slot = (p >= PAD_W'(NUM_THR_REGS)) ? p - PAD_W'(NUM_THR_REGS) : p;
	endfunction

	function automatic logic [NOTE_W-1:0] note_of(input logic [PAD_W-1:0] slot);
		case (slot)
			3'd0: note_of = 7'd38;
			3'd1: note_of = 7'd42;
			3'd2: note_of = 7'd45;
			3'd3: note_of = 7'd36;
			3'd4: note_of = 7'd51;
			3'd5: note_of = 7'd39;
			default: note_of = 7'd38;
		endcase
	endfunction

	function automatic logic [THR_W-1:0] thr_reset(input logic [PAD_W-1:0] slot);
		case (slot)
			3'd0: thr_reset = 10'd80;
			3'd1: thr_reset = 10'd40;
			3'd2: thr_reset = 10'd60;
			3'd3: thr_reset = 10'd60;
			3'd4: thr_reset = 10'd60;
			3'd5: thr_reset = 10'd30;
			default: thr_reset = 10'd60;
		endcase
	endfunction

endpackage

[hw/rtl/piezo_pad_peak_trigger_core.sv]
// Piezo pad trigger: turns tagged converter samples into note-on and note-off items.
// The input channel (in_valid/in_ready) carries either a sample for one pad or a
// one millisecond tick, chosen by req_type. Ticks advance every pad's timer and
// never give a result. The output channel (out_valid/out_ready) carries at most
// one event item per input item, in input order.
// A tick, or a sample that gives no result, leaves the block ready for the next item.
// A note-off, or a note-on whose velocity is fixed at 1 or 127, goes from the push state
// into the output register once that register is free, and the next item is taken after
// that. Any other note-on first passes the bit-serial velocity divider, which produces one
// quotient bit per cycle over the 17-bit scaled excess of the peak over its threshold.
// The output register parts the two channels: a new item is accepted while an
// earlier result still waits. If the receiver stalls and a second result is ready,
// the block holds that result and takes no further item until the register frees.
// Reset clears every pad to idle with zeroed timers, restores the default
// thresholds and windows, and empties the output register.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and are
// meant to be made while the block is idle.
module piezo_pad_peak_trigger_core
	import pppt_pkg::*;
#(
	parameter int NUM_PADS = NUM_PADS_DEF,
	parameter int SAMPLE_MAX = SAMPLE_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [PAD_W-1:0]      pad,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  event_kind,
	output logic [PAD_W-1:0]      pad_index,
	output logic [NOTE_W-1:0]     note_number,
	output logic [VEL_W-1:0]      velocity
);

	localparam int IDX_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
	localparam int MAX_W = $clog2(SAMPLE_MAX + 1);
	localparam int CMP_W = (MAX_W > THR_W) ? MAX_W : THR_W;
	localparam int NUM_W = SAMPLE_W + VEL_W;
	localparam int PCMP_W = 5;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_TRACK = 2'd1,
		MODE_AFTER = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH
	} state_t;

	state_t             state_q;
	mode_t              mode_q [NUM_PADS];
	logic [MS_W-1:0]    timer_q [NUM_PADS];
	logic [SAMPLE_W-1:0] peak_q [NUM_PADS];
	logic [THR_W-1:0]   thr_q [NUM_THR_REGS];
	logic [MS_W-1:0]    pkwin_q;
	logic [MS_W-1:0]    qwin_q;

	logic               pend_kind_q;
	logic [PAD_W-1:0]   pend_pad_q;
	logic [NOTE_W-1:0]  pend_note_q;
	logic [VEL_W-1:0]   pend_vel_q;

	logic               out_valid_q;
	logic               out_kind_q;
	logic [PAD_W-1:0]   out_pad_q;
	logic [NOTE_W-1:0]  out_note_q;
	logic [VEL_W-1:0]   out_vel_q;

	logic               acc;
	logic               push;
	logic               is_sample;
	logic               pad_ok;
	logic [PAD_W-1:0]   slot;
	logic [IDX_W-1:0]   idx;
	logic [THR_W-1:0]   cur_thr;
	mode_t              cur_mode;
	logic [SAMPLE_W-1:0] cur_peak;
	logic [MS_W-1:0]    cur_timer;
	logic               hit;
	logic [SAMPLE_W-1:0] new_peak;
	logic               win_done;
	logic               quiet_done;
	logic [CMP_W-1:0]   thr_ext;
	logic               thr_big;
	logic               above;
	logic [SAMPLE_W-1:0] diff;
	logic [NUM_W-1:0]   num;
	logic [MAX_W-1:0]   den;
	logic               div_start;
	logic               div_done;
	logic [NUM_W-1:0]   quot;
	logic [VEL_W-1:0]   div_vel;

	assign in_ready = (state_q == ST_IDLE);
	assign acc = in_valid && in_ready;
	assign push = (state_q == ST_PUSH) && (!out_valid_q || out_ready);
	assign is_sample = (req_type == REQ_SAMPLE);
	assign pad_ok = PCMP_W'(pad) < PCMP_W'(NUM_PADS);

	assign slot = thr_slot(pad);
	assign idx = IDX_W'(pad);
	assign cur_thr = thr_q[slot];
	assign cur_mode = mode_q[idx];
	assign cur_peak = peak_q[idx];
	assign cur_timer = timer_q[idx];

	assign hit = sample > cur_thr;
	assign new_peak = (sample > cur_peak) ? sample : cur_peak;
	assign win_done = cur_timer >= pkwin_q;
	assign quiet_done = (cur_timer > qwin_q) || (cur_timer == TIMER_MAX);

	assign thr_ext = CMP_W'(cur_thr);
	assign thr_big = thr_ext >= CMP_W'(SAMPLE_MAX);
	assign above = new_peak > cur_thr;
	assign diff = new_peak - cur_thr;
	assign num = (NUM_W'(diff) << 7) - (NUM_W'(diff) << 1);
	assign den = MAX_W'(CMP_W'(SAMPLE_MAX) - thr_ext);

	assign div_start = acc && is_sample && pad_ok && (cur_mode == MODE_TRACK) && win_done
		&& !thr_big && above;

	assign div_vel = (quot >= NUM_W'(VEL_MAX)) ? VEL_MAX : VEL_W'(quot) + VEL_MIN;

	pppt_div #(
		.NUM_W(NUM_W),
		.DEN_W(MAX_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(num),
		.den(den),
		.done(div_done),
		.quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_THR_REGS; i++) begin
				thr_q[i] <= thr_reset(PAD_W'(i));
			end
			pkwin_q <= PEAK_WINDOW_RST;
			qwin_q <= QUIET_WINDOW_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_PEAK_WINDOW) begin
				pkwin_q <= cfg_data[MS_W-1:0];
			end else if (cfg_index == REG_QUIET_WINDOW) begin
				qwin_q <= cfg_data[MS_W-1:0];
			end else begin
				thr_q[cfg_index] <= cfg_data[THR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_sample && pad_ok) begin
			if (cur_mode == MODE_IDLE && hit) begin
				peak_q[idx] <= sample;
			end else if (cur_mode == MODE_TRACK) begin
				peak_q[idx] <= new_peak;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < NUM_PADS; i++) begin
				mode_q[i] <= MODE_IDLE;
				timer_q[i] <= '0;
			end
			pend_kind_q <= EV_NOTE_ON;
			pend_pad_q <= '0;
			pend_note_q <= '0;
			pend_vel_q <= '0;
			out_valid_q <= 1'b0;
			out_kind_q <= EV_NOTE_ON;
			out_pad_q <= '0;
			out_note_q <= '0;
			out_vel_q <= '0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (!is_sample) begin
							for (int i = 0; i < NUM_PADS; i++) begin
								if (timer_q[i] != TIMER_MAX) begin
									timer_q[i] <= timer_q[i] + 1'b1;
								end
							end
						end else if (pad_ok) begin
							pend_pad_q <= pad;
							pend_note_q <= note_of(slot);
							case (cur_mode)
								MODE_IDLE: begin
									if (hit) begin
										timer_q[idx] <= '0;
										mode_q[idx] <= MODE_TRACK;
									end
								end
								MODE_TRACK: begin
									if (win_done) begin
										timer_q[idx] <= '0;
										mode_q[idx] <= MODE_AFTER;
										pend_kind_q <= EV_NOTE_ON;
										if (thr_big) begin
											pend_vel_q <= VEL_MAX;
											state_q <= ST_PUSH;
										end else if (!above) begin
											pend_vel_q <= VEL_MIN;
											state_q <= ST_PUSH;
										end else begin
											state_q <= ST_DIV;
										end
									end
								end
								default: begin
									if (hit) begin
										timer_q[idx] <= '0;
									end else if (quiet_done) begin
										mode_q[idx] <= MODE_IDLE;
										pend_kind_q <= EV_NOTE_OFF;
										pend_vel_q <= VEL_OFF;
										state_q <= ST_PUSH;
									end
								end
							endcase
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						pend_vel_q <= div_vel;
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push) begin
						out_kind_q <= pend_kind_q;
						out_pad_q <= pend_pad_q;
						out_note_q <= pend_note_q;
						out_vel_q <= pend_vel_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign event_kind = out_kind_q;
	assign pad_index = out_pad_q;
	assign note_number = out_note_q;
	assign velocity = out_vel_q;

endmodule

[hw/rtl/pppt_div.sv]
module pppt_div #(
	parameter int NUM_W = 17,
	parameter int DEN_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W:0]   diff;

	// One quotient bit per cycle; the dividend shifts out as the quotient shifts in.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
	import pppt_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int VEL_SPAN = 126;
	localparam logic [CFG_IDX_W-1:0] REG_THR_BASE = 3'd0;
	localparam logic [NOTE_W-1:0] PAD_NOTES [NUM_THR_REGS] = '{
		7'd38, 7'd42, 7'd45, 7'd36, 7'd51, 7'd39
	};
	localparam logic [THR_W-1:0] THR_DEFAULTS [NUM_THR_REGS] = '{
		10'd80, 10'd40, 10'd60, 10'd60, 10'd60, 10'd30
	};

	typedef enum logic [1:0] {
		PAD_IDLE  = 2'd0,
		PAD_TRACK = 2'd1,
		PAD_AFTER = 2'd2
	} pad_mode_e;

	typedef struct {
		logic                req;
		logic [PAD_W-1:0]    pad;
		logic [SAMPLE_W-1:0] smp;
	} pad_item_t;

	typedef struct {
		logic              kind;
		logic [PAD_W-1:0]  pad;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
	} note_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = REQ_SAMPLE;
	logic [PAD_W-1:0] pad = '0;
	logic [SAMPLE_W-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic event_kind;
	logic [PAD_W-1:0] pad_index;
	logic [NOTE_W-1:0] note_number;
	logic [VEL_W-1:0] velocity;

	pad_item_t stim_items [$];
	note_event_t expected_events [$];
	int n_queued = 0;
	int n_accepted = 0;
	int n_errors = 0;
	int cycle_count = 0;
	int send_idle = 29;
	int recv_idle = 52;

	logic [THR_W-1:0] thr_cfg [NUM_THR_REGS] = THR_DEFAULTS;
	logic [MS_W-1:0] peak_win = PEAK_WINDOW_RST;
	logic [MS_W-1:0] quiet_win = QUIET_WINDOW_RST;
	pad_mode_e pad_state [NUM_PADS_DEF] = '{default: PAD_IDLE};
	logic [SAMPLE_W-1:0] pad_peak [NUM_PADS_DEF] = '{default: '0};
	logic [MS_W-1:0] pad_ms [NUM_PADS_DEF] = '{default: '0};

	piezo_pad_peak_trigger_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.pad(pad),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.pad_index(pad_index),
		.note_number(note_number),
		.velocity(velocity)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [VEL_W-1:0] scaled_velocity(input logic [SAMPLE_W-1:0] pk,
			input logic [THR_W-1:0] thr);
		int unsigned num;
		int unsigned den;
		int unsigned v;
		if (thr >= SAMPLE_MAX_DEF)
			return VEL_MAX;
		if (pk <= thr)
			return VEL_MIN;
		num = pk;
		num = num - thr;
		den = SAMPLE_MAX_DEF - thr;
		v = num * VEL_SPAN / den + 1;
		if (v > VEL_MAX)
			return VEL_MAX;
		return VEL_W'(v);
	endfunction

	function automatic bit pad_event_for(input logic rq, input logic [PAD_W-1:0] p,
			input logic [SAMPLE_W-1:0] s, output note_event_t ev);
		int i;
		int slot;
		logic [THR_W-1:0] thr;
		ev = '{kind: EV_NOTE_ON, pad: p, note: '0, vel: VEL_OFF};
		if (rq == REQ_TICK) begin
			for (i = 0; i < NUM_PADS_DEF; i++)
				if (pad_ms[i] != TIMER_MAX)
					pad_ms[i] = pad_ms[i] + 1'b1;
			return 1'b0;
		end
		if (p >= NUM_PADS_DEF)
			return 1'b0;
		slot = p % NUM_THR_REGS;
		thr = thr_cfg[slot];
		ev.note = PAD_NOTES[slot];
		case (pad_state[p])
			PAD_IDLE: begin
				if (s > thr) begin
					pad_peak[p] = s;
					pad_ms[p] = '0;
					pad_state[p] = PAD_TRACK;
				end
			end
			PAD_TRACK: begin
				if (s > pad_peak[p])
					pad_peak[p] = s;
				if (pad_ms[p] >= peak_win) begin
					ev.kind = EV_NOTE_ON;
					ev.vel = scaled_velocity(pad_peak[p], thr);
					pad_ms[p] = '0;
					pad_state[p] = PAD_AFTER;
					return 1'b1;
				end
			end
			default: begin
				if (s > thr) begin
					pad_ms[p] = '0;
				end else if (pad_ms[p] > quiet_win || pad_ms[p] == TIMER_MAX) begin
					ev.kind = EV_NOTE_OFF;
					ev.vel = VEL_OFF;
					pad_state[p] = PAD_IDLE;
					return 1'b1;
				end
			end
		endcase
		return 1'b0;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		n_errors++;
	endtask

	task automatic queue_item(input logic rq, input int p, input int s);
		pad_item_t it;
		it.req = rq;
		it.pad = PAD_W'(p);
		it.smp = SAMPLE_W'(s);
		stim_items.push_back(it);
		n_queued++;
	endtask

	task automatic queue_ticks(input int n);
		int k;
		for (k = 0; k < n; k++)
			queue_item(REQ_TICK, $urandom_range(7), $urandom_range(1023));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		if (idx < NUM_THR_REGS)
			thr_cfg[idx] = THR_W'(value);
		else if (idx == REG_PEAK_WINDOW)
			peak_win = MS_W'(value);
		else if (idx == REG_QUIET_WINDOW)
			quiet_win = MS_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_settings(input logic [THR_W-1:0] thr_set [NUM_THR_REGS],
			input int pw, input int qw);
		int i;
		for (i = 0; i < NUM_THR_REGS; i++)
			write_reg(REG_THR_BASE + CFG_IDX_W'(i), thr_set[i]);
		write_reg(REG_PEAK_WINDOW, pw);
		write_reg(REG_QUIET_WINDOW, qw);
	endtask

	task automatic wait_idle();
		while (n_accepted != n_queued || expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_threshold();
		int r;
		r = $urandom_range(15);
		if (r < 2)
			return 0;
		if (r < 4)
			return 1022;
		if (r == 4)
			return 1023;
		return $urandom_range(10, 900);
	endfunction

	always @(posedge clk) begin : driver
		pad_item_t nxt;
		note_event_t ev;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				n_accepted++;
				if (pad_event_for(req_type, pad, sample, ev))
					expected_events.push_back(ev);
			end
			if (!in_valid || in_ready) begin
				if (stim_items.size() != 0 && $urandom_range(99) >= send_idle) begin
					nxt = stim_items.pop_front();
					in_valid <= 1'b1;
					req_type <= nxt.req;
					pad <= nxt.pad;
					sample <= nxt.smp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin : monitor
		note_event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				flag_mismatch($sformatf("unexpected event kind %0d pad %0d", event_kind,
					pad_index));
			end else begin
				want = expected_events.pop_front();
				if (event_kind !== want.kind)
					flag_mismatch($sformatf("event_kind %0d, wanted %0d", event_kind,
						want.kind));
				if (pad_index !== want.pad)
					flag_mismatch($sformatf("pad_index %0d, wanted %0d", pad_index,
						want.pad));
				if (note_number !== want.note)
					flag_mismatch($sformatf("note_number %0d, wanted %0d", note_number,
						want.note));
				if (velocity !== want.vel)
					flag_mismatch($sformatf("velocity %0d, wanted %0d", velocity,
						want.vel));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("[piezo_pad_peak_trigger_core] ERROR");
			$finish;
		end
	end

	initial begin
		int ph;
		int k;
		int r;
		int p;
		int thr;
		int lo;
		int hi;
		logic [THR_W-1:0] thr_set [NUM_THR_REGS];

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme thresholds and zero windows keep the directed hits short.
		thr_set = '{10'd0, 10'd1022, 10'd500, 10'd500, 10'd60, 10'd30};
		load_settings(thr_set, 0, 0);
		queue_item(REQ_SAMPLE, 0, 1023);
		queue_item(REQ_SAMPLE, 0, 0);
		queue_item(REQ_SAMPLE, 0, 0);
		queue_ticks(1);
		queue_item(REQ_SAMPLE, 0, 0);
		queue_item(REQ_SAMPLE, 6, 1023);
		queue_item(REQ_SAMPLE, 7, 0);
		queue_item(REQ_SAMPLE, 1, 1022);
		queue_item(REQ_SAMPLE, 1, 1023);
		queue_item(REQ_SAMPLE, 1, 0);
		queue_item(REQ_SAMPLE, 2, 600);
		queue_item(REQ_SAMPLE, 3, 900);
		queue_item(REQ_SAMPLE, 4, 60);
		queue_item(REQ_SAMPLE, 5, 0);
		wait_idle();

		// Raising the thresholds under tracking pads gives the floor and ceiling velocities.
		write_reg(REG_THR_BASE + CFG_IDX_W'(2), 700);
		write_reg(REG_THR_BASE + CFG_IDX_W'(3), 1023);
		queue_item(REQ_SAMPLE, 2, 0);
		queue_item(REQ_SAMPLE, 3, 0);
		queue_item(REQ_SAMPLE, 4, 61);
		queue_item(REQ_SAMPLE, 4, 0);
		queue_ticks(1);
		queue_item(REQ_SAMPLE, 4, 1023);
		queue_item(REQ_SAMPLE, 4, 0);
		queue_ticks(1);
		queue_item(REQ_SAMPLE, 4, 0);
		wait_idle();

		// Full windows: the timer must saturate before either event is released.
		load_settings(THR_DEFAULTS, 255, 255);
		queue_item(REQ_SAMPLE, 5, 500);
		queue_ticks(300);
		queue_item(REQ_SAMPLE, 5, 0);
		queue_ticks(300);
		queue_item(REQ_SAMPLE, 5, 0);
		wait_idle();

		for (ph = 0; ph < 9; ph++) begin
			if (ph < 3) begin
				send_idle = 29;
				recv_idle = 52;
			end else if (ph < 6) begin
				send_idle = 52;
				recv_idle = 29;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (k = 0; k < NUM_THR_REGS; k++)
				thr_set[k] = THR_W'(pick_threshold());
			if (ph == 0)
				load_settings(thr_set, 0, 0);
			else
				load_settings(thr_set, $urandom_range(0, 6), $urandom_range(0, 8));
			for (k = 0; k < 80; k++) begin
				r = $urandom_range(99);
				if (r < 35) begin
					queue_ticks(1);
				end else if (r < 38) begin
					queue_item(REQ_SAMPLE, $urandom_range(6, 7), $urandom_range(1023));
				end else begin
					p = $urandom_range(0, NUM_PADS_DEF - 1);
					thr = thr_cfg[p % NUM_THR_REGS];
					case ($urandom_range(3))
						0: queue_item(REQ_SAMPLE, p, $urandom_range(1023));
						1: queue_item(REQ_SAMPLE, p,
							(thr >= 1023) ? 1023 : $urandom_range(thr + 1, 1023));
						2: queue_item(REQ_SAMPLE, p, $urandom_range(0, thr));
						default: begin
							lo = (thr > 2) ? thr - 2 : 0;
							hi = (thr + 2 > 1023) ? 1023 : thr + 2;
							queue_item(REQ_SAMPLE, p, $urandom_range(lo, hi));
						end
					endcase
				end
			end
			wait_idle();
		end

		if (n_errors == 0)
			$display("[piezo_pad_peak_trigger_core] OK");
		else
			$display("[piezo_pad_peak_trigger_core] ERROR");
		$finish;
	end

endmodule
